FILE: rtl/aat_pkg.sv
`default_nettype none

package aat_pkg;

    localparam int NumAxes  = 3;
    localparam int CoordW   = 32;
    localparam int ProdW    = 2 * CoordW;
    localparam int FracW    = 16;
    localparam int RndW     = ProdW - FracW;
    localparam int SumW     = RndW + 2;
    localparam int CfgW     = 64;
    localparam int NumRegs  = 6;
    localparam int RegIdxW  = $clog2(NumRegs);
    localparam int BoxW     = 2 * NumAxes * CoordW;

    // register indexes of the matrix rows
    typedef enum logic [RegIdxW-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } cfg_reg_t;

    localparam logic [RegIdxW-1:0] RegLast = REG_ROW2_COLS23;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [RndW-1:0]   rnd_t;
    typedef logic signed [SumW-1:0]   sum_t;
    typedef logic [CfgW-1:0]          cfg_word_t;

    // identity matrix, no translation
    localparam cfg_word_t CfgRow0Cols01Rst = 64'h0000_0000_0001_0000;
    localparam cfg_word_t CfgRow0Cols23Rst = 64'h0000_0000_0000_0000;
    localparam cfg_word_t CfgRow1Cols01Rst = 64'h0001_0000_0000_0000;
    localparam cfg_word_t CfgRow1Cols23Rst = 64'h0000_0000_0000_0000;
    localparam cfg_word_t CfgRow2Cols01Rst = 64'h0000_0000_0000_0000;
    localparam cfg_word_t CfgRow2Cols23Rst = 64'h0000_0000_0001_0000;

    localparam prod_t RndHalf = prod_t'(1) <<< (FracW - 1);
    localparam sum_t  SatMax  = sum_t'(coord_t'({1'b0, {(CoordW-1){1'b1}}}));
    localparam sum_t  SatMin  = sum_t'(coord_t'({1'b1, {(CoordW-1){1'b0}}}));

    // q32.32 product of two q16.16 values rounded to nearest, ties up (floor of p + half)
    function automatic rnd_t round_prod(input prod_t p);
        prod_t t;
        t = p + RndHalf;
        return rnd_t'(t[ProdW-1:FracW]);
    endfunction

    function automatic coord_t sat_coord(input sum_t s);
        coord_t r;
        if (s > SatMax)
            r = coord_t'(SatMax);
        else if (s < SatMin)
            r = coord_t'(SatMin);
        else
            r = coord_t'(s);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/aabb_affine_transform.sv
`default_nettype none

// Transforms a local axis-aligned box through a 3x4 affine matrix and returns the
// world-space box enclosing all eight corners, per axis as translation plus the sum
// of the smaller (larger) of coefficient*min and coefficient*max. All values are
// signed Q16.16; each product is rounded to nearest (ties up), sums are exact and
// only the final result saturates to 32 bits. The pipeline has five register stages
// (input, products, round and order, sum, saturate to the output register), and one
// box is taken every clock while the output side keeps tready high. Each of the nine
// matrix coefficients has two 32x32 multipliers, eighteen in all, which set the
// one-box-per-cycle rate. The user must write the matrix registers over the cfg
// port only while no box is in flight; the block itself does not enforce it.

module aabb_affine_transform
    import aat_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  wire logic [BoxW-1:0]     s_axis_tdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
    output logic [BoxW-1:0]          m_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [RegIdxW-1:0]  cfg_index,
    input  wire logic [CfgW-1:0]     cfg_data
);

    cfg_word_t cfg_reg [NumRegs];

    logic   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic   en0, en1, en2, en3, en4;

    coord_t lo_reg   [NumAxes];
    coord_t hi_reg   [NumAxes];
    prod_t  plo_reg  [NumAxes][NumAxes];
    prod_t  phi_reg  [NumAxes][NumAxes];
    rnd_t   mn_reg   [NumAxes][NumAxes];
    rnd_t   mx_reg   [NumAxes][NumAxes];
    sum_t   smin_reg [NumAxes];
    sum_t   smax_reg [NumAxes];
    logic [BoxW-1:0] out_reg;

    coord_t coef  [NumAxes][NumAxes];
    coord_t trans [NumAxes];

    // ------------------------------------------------------------------ config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW0_COLS01] <= CfgRow0Cols01Rst;
            cfg_reg[REG_ROW0_COLS23] <= CfgRow0Cols23Rst;
            cfg_reg[REG_ROW1_COLS01] <= CfgRow1Cols01Rst;
            cfg_reg[REG_ROW1_COLS23] <= CfgRow1Cols23Rst;
            cfg_reg[REG_ROW2_COLS01] <= CfgRow2Cols01Rst;
            cfg_reg[REG_ROW2_COLS23] <= CfgRow2Cols23Rst;
        end
        else if (cfg_valid && cfg_index <= RegLast)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // row r: cols01 holds c0 low and c1 high, cols23 holds c2 low and translation high
    always_comb
    begin
        for (int r = 0; r < NumAxes; r++)
        begin
            coef[r][0] = coord_t'(cfg_reg[2*r][CoordW-1:0]);
            coef[r][1] = coord_t'(cfg_reg[2*r][CfgW-1:CoordW]);
            coef[r][2] = coord_t'(cfg_reg[2*r+1][CoordW-1:0]);
            trans[r]   = coord_t'(cfg_reg[2*r+1][CfgW-1:CoordW]);
        end
    end

    // ------------------------------------------------------------ flow control
    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign s_axis_tready = en0;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en0)
                v0_reg <= s_axis_tvalid;
            if (en1)
                v1_reg <= v0_reg;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // ----------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            for (int c = 0; c < NumAxes; c++)
            begin
                lo_reg[c] <= coord_t'(s_axis_tdata[c*CoordW +: CoordW]);
                hi_reg[c] <= coord_t'(s_axis_tdata[(c+NumAxes)*CoordW +: CoordW]);
            end
        end

        if (en1)
        begin
            for (int r = 0; r < NumAxes; r++)
            begin
                for (int c = 0; c < NumAxes; c++)
                begin
                    plo_reg[r][c] <= prod_t'(coef[r][c]) * prod_t'(lo_reg[c]);
                    phi_reg[r][c] <= prod_t'(coef[r][c]) * prod_t'(hi_reg[c]);
                end
            end
        end

        // ordering uses the rounded values
        if (en2)
        begin
            for (int r = 0; r < NumAxes; r++)
            begin
                for (int c = 0; c < NumAxes; c++)
                begin
                    if (round_prod(plo_reg[r][c]) < round_prod(phi_reg[r][c]))
                    begin
                        mn_reg[r][c] <= round_prod(plo_reg[r][c]);
                        mx_reg[r][c] <= round_prod(phi_reg[r][c]);
                    end
                    else
                    begin
                        mn_reg[r][c] <= round_prod(phi_reg[r][c]);
                        mx_reg[r][c] <= round_prod(plo_reg[r][c]);
                    end
                end
            end
        end

        if (en3)
        begin
            for (int r = 0; r < NumAxes; r++)
            begin
                smin_reg[r] <= sum_t'(trans[r]) + sum_t'(mn_reg[r][0])
                             + sum_t'(mn_reg[r][1]) + sum_t'(mn_reg[r][2]);
                smax_reg[r] <= sum_t'(trans[r]) + sum_t'(mx_reg[r][0])
                             + sum_t'(mx_reg[r][1]) + sum_t'(mx_reg[r][2]);
            end
        end

        if (en4)
        begin
            for (int r = 0; r < NumAxes; r++)
            begin
                out_reg[r*CoordW +: CoordW]           <= sat_coord(smin_reg[r]);
                out_reg[(r+NumAxes)*CoordW +: CoordW] <= sat_coord(smax_reg[r]);
            end
        end
    end

    // --------------------------------------------------------------- assertions
    for (genvar r = 0; r < NumAxes; r++)
    begin : g_chk
        a_term_order: assert property (@(posedge clk) disable iff (!rst_n)
            v2_reg |-> (mn_reg[r][0] <= mx_reg[r][0]) && (mn_reg[r][1] <= mx_reg[r][1])
                       && (mn_reg[r][2] <= mx_reg[r][2]))
            else $error("ordered product pair swapped");

        a_sum_order: assert property (@(posedge clk) disable iff (!rst_n)
            v3_reg |-> smin_reg[r] <= smax_reg[r])
            else $error("world minimum sum above maximum");

        a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
            v4_reg |-> $signed(out_reg[r*CoordW +: CoordW])
                       <= $signed(out_reg[(r+NumAxes)*CoordW +: CoordW]))
            else $error("saturated output minimum above maximum");
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_aabb_affine_transform.sv
`timescale 1ns / 100ps

module tb_aabb_affine_transform;
    import aat_pkg::*;

    localparam int StallLimit = 2000;
    localparam int BacklogCycles = 300;
    localparam int BoxFields = 2 * NumAxes;
    localparam longint QMax = 64'sd2147483647;
    localparam longint QMin = -64'sd2147483648;

    // indexes past the last matrix register, writes there must be dropped
    localparam logic [RegIdxW-1:0] IdxSpareLo = RegLast + 3'd1;
    localparam logic [RegIdxW-1:0] IdxSpareHi = RegLast + 3'd2;

    typedef enum int {VAL_SMALL, VAL_FULL, VAL_EDGE} value_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

    // holds the matrix and the world boxes still owed by the block
    class world_box_tracker;
        cfg_word_t matrix [NumRegs];
        logic [BoxW-1:0] world_boxes_due [$];
        string field_tag [BoxFields];
        int errors;

        function new();
            matrix[REG_ROW0_COLS01] = CfgRow0Cols01Rst;
            matrix[REG_ROW0_COLS23] = CfgRow0Cols23Rst;
            matrix[REG_ROW1_COLS01] = CfgRow1Cols01Rst;
            matrix[REG_ROW1_COLS23] = CfgRow1Cols23Rst;
            matrix[REG_ROW2_COLS01] = CfgRow2Cols01Rst;
            matrix[REG_ROW2_COLS23] = CfgRow2Cols23Rst;
            field_tag = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
            errors = 0;
        endfunction

        function void note_reg(logic [RegIdxW-1:0] idx, cfg_word_t value);
            if (idx <= RegLast)
                matrix[idx] = value;
        endfunction

        // exact q32.32 product, then round to nearest with ties up
        function longint scale_coord(longint coef, longint coord);
            return (coef * coord + 64'sd32768) >>> 16;
        endfunction

        function logic [CoordW-1:0] clamp_coord(longint v);
            if (v > QMax)
                return 32'h7FFF_FFFF;
            if (v < QMin)
                return 32'h8000_0000;
            return v[CoordW-1:0];
        endfunction

        function logic [BoxW-1:0] transform_box(logic [BoxW-1:0] box);
            logic [BoxW-1:0] world;
            longint coef [NumAxes];
            longint lo, hi, p, q, smin, smax;
            for (int r = 0; r < NumAxes; r++)
            begin
                coef[0] = longint'($signed(matrix[2*r][31:0]));
                coef[1] = longint'($signed(matrix[2*r][63:32]));
                coef[2] = longint'($signed(matrix[2*r+1][31:0]));
                smin = longint'($signed(matrix[2*r+1][63:32]));
                smax = smin;
                for (int c = 0; c < NumAxes; c++)
                begin
                    lo = longint'($signed(box[c*CoordW +: CoordW]));
                    hi = longint'($signed(box[(c+NumAxes)*CoordW +: CoordW]));
                    p = scale_coord(coef[c], lo);
                    q = scale_coord(coef[c], hi);
                    if (p < q)
                    begin
                        smin += p;
                        smax += q;
                    end
                    else
                    begin
                        smin += q;
                        smax += p;
                    end
                end
                world[r*CoordW +: CoordW] = clamp_coord(smin);
                world[(r+NumAxes)*CoordW +: CoordW] = clamp_coord(smax);
            end
            return world;
        endfunction

        function void note_box(logic [BoxW-1:0] box);
            world_boxes_due.push_back(transform_box(box));
        endfunction

        function void check_world(logic [BoxW-1:0] world);
            logic [BoxW-1:0] want;
            if (world_boxes_due.size() == 0)
            begin
                $display("%0t: world box with none due, actual %h", $time, world);
                errors++;
                return;
            end
            want = world_boxes_due.pop_front();
            for (int f = 0; f < BoxFields; f++)
                if (world[f*CoordW +: CoordW] !== want[f*CoordW +: CoordW])
                begin
                    $display("%0t: world %s expected %h actual %h", $time, field_tag[f],
                             want[f*CoordW +: CoordW], world[f*CoordW +: CoordW]);
                    errors++;
                end
        endfunction

        function int pending();
            return world_boxes_due.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic [BoxW-1:0]     s_axis_tdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [BoxW-1:0]     m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RegIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_data;

    logic                backlog_req = 1'b0;
    logic                backlog_done = 1'b0;
    int                  quiet_cycles = 0;
    cfg_word_t           matrix_plan [NumRegs];
    world_box_tracker    tracker = new();

    aabb_affine_transform uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            tracker.note_box(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            tracker.check_world(m_axis_tdata);
        if (cfg_valid && cfg_ready)
            tracker.note_reg(cfg_index, cfg_data);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: no request moved for %0d cycles", $time, StallLimit);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: changing stall patterns, plus one long hold-off on demand
    initial
    begin
        rx_pattern_t pattern;
        int span;
        int tick;
        m_axis_tready = 1'b0;
        pattern = RX_OPEN;
        span = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (backlog_req && !backlog_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (BacklogCycles - 1) @(negedge clk);
                backlog_done = 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 96);
                end
                span--;
                case (pattern)
                    RX_OPEN:     m_axis_tready <= 1'b1;
                    RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:     m_axis_tready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    function automatic logic [BoxW-1:0] pack_box(coord_t mnx, coord_t mny, coord_t mnz,
                                                 coord_t mxx, coord_t mxy, coord_t mxz);
        return {mxz, mxy, mxx, mnz, mny, mnx};
    endfunction

    function automatic coord_t random_value(value_kind_t kind, int span);
        coord_t v;
        case (kind)
            VAL_SMALL: v = coord_t'(int'($urandom_range(0, 2 * span)) - span);
            VAL_FULL:  v = $urandom;
            default:
                case ($urandom_range(0, 5))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    4:       v = 32'h0001_0000;
                    default: v = 32'h0000_8000;
                endcase
        endcase
        return v;
    endfunction

    function automatic value_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return VAL_SMALL;
        if (roll < 8)
            return VAL_FULL;
        return VAL_EDGE;
    endfunction

    function automatic logic [BoxW-1:0] random_box();
        logic [BoxW-1:0] box;
        value_kind_t kind;
        kind = pick_kind();
        for (int f = 0; f < BoxFields; f++)
            box[f*CoordW +: CoordW] = random_value(kind, 1 << 20);
        return box;
    endfunction

    task automatic random_matrix();
        for (int i = 0; i < NumRegs; i++)
            matrix_plan[i] = {random_value(pick_kind(), 1 << 17),
                              random_value(pick_kind(), 1 << 17)};
    endtask

    task automatic offer_box(input logic [BoxW-1:0] box);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= box;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= {6{$urandom}};
        end
    endtask

    task automatic stream_boxes(input int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            burst--;
            offer_box(random_box());
        end
        pause_sender(1);
    endtask

    task automatic program_reg(input logic [RegIdxW-1:0] idx, input cfg_word_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // matrix from matrix_plan, then a stray write that must not land anywhere
    task automatic load_matrix();
        for (int i = 0; i < NumRegs; i++)
            program_reg(RegIdxW'(i), matrix_plan[i]);
        program_reg($urandom_range(0, 1) ? IdxSpareHi : IdxSpareLo, {$urandom, $urandom});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tracker.pending() != 0);
    endtask

    initial
    begin
        cfg_word_t uniform [4];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROW0_COLS01;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity matrix from reset
        offer_box(pack_box(0, 0, 0, 0, 0, 0));
        offer_box(pack_box(-32'sh10000, -32'sh10000, -32'sh10000,
                           32'sh10000, 32'sh10000, 32'sh10000));
        offer_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // inverted on every axis
        offer_box(pack_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        offer_box(pack_box(5, -7, 32'sh12345, -5, 7, -32'sh12345));
        offer_box({6{32'h7FFF_FFFF}});
        offer_box({6{32'hFFFF_FFFF}});
        pause_sender(1);

        // half-step coefficients give rounding ties, big translations saturate
        matrix_plan = '{64'hFFFF_8000_0000_8000, 64'h7FFF_0000_0000_8000,
                        64'h7FFF_FFFF_FFFF_8000, 64'h8000_0000_8000_0000,
                        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000};
        wait_drained();
        load_matrix();
        offer_box(pack_box(1, 1, 1, 1, 1, 1));
        offer_box(pack_box(-1, -1, -1, -1, -1, -1));
        offer_box(pack_box(3, -3, 1, -1, 3, -3));
        offer_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        offer_box(pack_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        offer_box(pack_box(32'sh10001, -32'sh18001, 32'sh7FFF, -32'sh10001, 32'sh18001, 0));
        pause_sender(1);

        // every coefficient and translation at one shared value per pass: all ones, minimum, zero, maximum
        uniform = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_8000_0000,
                    64'h0000_0000_0000_0000, 64'h7FFF_FFFF_7FFF_FFFF};
        foreach (uniform[u])
        begin
            matrix_plan = '{default: uniform[u]};
            wait_drained();
            load_matrix();
            stream_boxes(40);
        end

        for (int ph = 0; ph < 9; ph++)
        begin
            random_matrix();
            wait_drained();
            load_matrix();
            if (ph == 2)
            begin
                @(posedge clk);
                backlog_req = 1'b1;
            end
            stream_boxes(70);
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
